@@ rtl/multilevel_slot_budget_scheduler_assert.svh @@
// Assertion macros shared by the scheduler modules.
`ifndef MULTILEVEL_SLOT_BUDGET_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_SLOT_BUDGET_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLSBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLSBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mlsbs_pkg.sv @@
`timescale 1ns / 1ps

package mlsbs_pkg;

  localparam int DEF_NUM_LEVELS  = 8;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam int PID_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int LEVEL_W = 8;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef struct packed {
    logic              op;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [PID_W-1:0]   out_pid;
    logic [LEVEL_W-1:0] out_level;
  } rsp_t;

  typedef struct packed {
    logic               dispatch;
    logic [PID_W-1:0]   pid;
    logic [LEVEL_W-1:0] level;
  } job_t;

endpackage

@@ rtl/mlsbs_front.sv @@
`timescale 1ns / 1ps
`include "multilevel_slot_budget_scheduler_assert.svh"

module mlsbs_front #(
  parameter int NUM_LEVELS = mlsbs_pkg::DEF_NUM_LEVELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mlsbs_pkg::req_t   cmd,
  output logic              job_valid,
  output mlsbs_pkg::job_t   job,
  input  logic              pop
);
  import mlsbs_pkg::*;

  job_t        slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  job_t        job_new;

  assign busy      = (count == 2'd2);
  assign push      = start && !busy;
  assign job_valid = (count != 2'd0);
  assign job       = slot[rd_ptr];

  // Requested priorities above the top level land on the top level.
  always_comb begin
    job_new.dispatch = cmd.op;
    job_new.pid      = cmd.pid;
    if ({1'b0, cmd.prio} >= (LEVEL_W + 1)'(NUM_LEVELS)) begin
      job_new.level = LEVEL_W'(NUM_LEVELS - 1);
    end else begin
      job_new.level = cmd.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= job_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `MLSBS_ASSERT_SAME(a_pop_nonempty, clk, rst, pop, count != 2'd0, "pop from empty queue")
  `MLSBS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= 2'd2, "queue count overflow")

endmodule

@@ rtl/mlsbs_back.sv @@
`timescale 1ns / 1ps
`include "multilevel_slot_budget_scheduler_assert.svh"

module mlsbs_back #(
  parameter int NUM_LEVELS  = mlsbs_pkg::DEF_NUM_LEVELS,
  parameter int QUEUE_DEPTH = mlsbs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  mlsbs_pkg::job_t   job_in,
  output logic              pop,
  output logic              done,
  output mlsbs_pkg::rsp_t   result
);
  import mlsbs_pkg::*;

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(NUM_LEVELS + 1);
  localparam int STORE_DEPTH = 1 << (LW + QW);

  typedef struct packed {
    logic [QW-1:0] head;
    logic [QW-1:0] tail;
    logic [CW-1:0] count;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADM,
    S_SCAN,
    S_DSP_REC,
    S_DSP_OUT
  } state_t;

  state_t              state;
  job_t                job;
  logic [LW-1:0]       job_lv;
  logic [LW-1:0]       cur_level;
  logic [SW-1:0]       served;
  logic [SW-1:0]       served_inc;
  logic [SW-1:0]       budget;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [NUM_LEVELS-1:0] rec_valid;

  rec_t                rec_mem [NUM_LEVELS];
  rec_t                rec_rd;
  logic                rec_rd_valid;
  rec_t                rec_cur;
  logic [LW-1:0]       rec_raddr;
  logic                rec_we;
  logic [LW-1:0]       rec_waddr;
  rec_t                rec_wdata;

  logic [PID_W-1:0]    store_mem [STORE_DEPTH];
  logic [PID_W-1:0]    store_q;
  logic                store_we;
  logic [LW+QW-1:0]    store_waddr;
  logic [LW+QW-1:0]    store_raddr;
  logic                full;

  function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] s);
    return (s == QW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [LW-1:0] next_level(input logic [LW-1:0] lv);
    return (lv == LW'(NUM_LEVELS - 1)) ? '0 : lv + 1'b1;
  endfunction

  assign job_lv     = job.level[LW-1:0];
  assign rec_cur    = rec_rd_valid ? rec_rd : '0;
  assign full       = (rec_cur.count == CW'(QUEUE_DEPTH));
  assign pop        = (state == S_IDLE) && job_valid;
  assign served_inc = served + 1'b1;
  assign budget     = SW'(NUM_LEVELS) - SW'(cur_level);
  assign store_we    = (state == S_ADM) && !full;
  assign store_waddr = {job_lv, rec_cur.tail};
  assign store_raddr = {cur_level, rec_cur.head};

  always_comb begin
    rec_raddr = cur_level;
    if (state == S_IDLE) begin
      rec_raddr = job_in.level[LW-1:0];
    end
    rec_we    = 1'b0;
    rec_waddr = cur_level;
    rec_wdata = rec_cur;
    if (state == S_ADM) begin
      rec_we          = !full;
      rec_waddr       = job_lv;
      rec_wdata.tail  = next_slot(rec_cur.tail);
      rec_wdata.count = rec_cur.count + 1'b1;
    end else if (state == S_DSP_REC) begin
      rec_we          = 1'b1;
      rec_wdata.head  = next_slot(rec_cur.head);
      rec_wdata.count = rec_cur.count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rd       <= rec_mem[rec_raddr];
    rec_rd_valid <= rec_valid[rec_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
    end else if (rec_we) begin
      rec_valid[rec_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= job.pid;
    end
    store_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      cur_level <= '0;
      served    <= '0;
      nonempty  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= job_valid && job_in.dispatch && (nonempty == '0);
          if (job_valid) begin
            job <= job_in;
            if (!job_in.dispatch) begin
              state <= S_ADM;
            end else if (nonempty == '0) begin
              result <= '{status: ST_NONE, out_pid: '0, out_level: '0};
              served <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_ADM: begin
          done   <= 1'b1;
          result <= '{status: (full ? ST_FULL : ST_OK), out_pid: '0,
                      out_level: job.level};
          if (!full) begin
            nonempty[job_lv] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          done <= 1'b0;
          if (nonempty[cur_level]) begin
            state <= S_DSP_REC;
          end else begin
            cur_level <= next_level(cur_level);
            served    <= '0;
          end
        end
        S_DSP_REC: begin
          done <= 1'b0;
          nonempty[cur_level] <= (rec_cur.count != CW'(1));
          state <= S_DSP_OUT;
        end
        S_DSP_OUT: begin
          done   <= 1'b1;
          result <= '{status: ST_OK, out_pid: store_q,
                      out_level: LEVEL_W'(cur_level)};
          if (served_inc >= budget) begin
            cur_level <= next_level(cur_level);
            served    <= '0;
          end else begin
            served <= served_inc;
          end
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MLSBS_ASSERT_SAME(a_scan_has_work, clk, rst, state == S_SCAN, nonempty != '0, "scan with all levels empty")
  `MLSBS_ASSERT_SAME(a_served_level_nonempty, clk, rst, state == S_DSP_REC, rec_cur.count != '0, "dispatch from empty level")
  `MLSBS_ASSERT_SAME(a_budget_bound, clk, rst, 1'b1, int'(served) < NUM_LEVELS - int'(cur_level), "served count over level budget")
  `MLSBS_ASSERT_NEXT(a_admit_answers, clk, rst, state == S_ADM, done && (result.status == ST_OK || result.status == ST_FULL), "admit without result")

endmodule

@@ rtl/multilevel_slot_budget_scheduler.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// command   in         start high, busy low        cmd   (op, pid, prio)
// result    out        done strobe, one cycle      result (status, out_pid, out_level)
//
// An accepted command enters a two-entry queue; the executing side pops it only while idle.
// An admit is answered from the admit state; a dispatch scans past empty levels one level per
// cycle, updates the record and returns the pid; an all-empty dispatch is answered in idle.
// The per-level record memory and the pid store each have one registered read port.
// Reset is synchronous; it empties all levels and returns the pointer to level 0.
// Busy rises only while the command queue holds two transactions; results are never held back.
module multilevel_slot_budget_scheduler #(
  parameter int NUM_LEVELS  = mlsbs_pkg::DEF_NUM_LEVELS,
  parameter int QUEUE_DEPTH = mlsbs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mlsbs_pkg::req_t   cmd,
  output logic              done,
  output mlsbs_pkg::rsp_t   result
);
  import mlsbs_pkg::*;

  logic  job_valid;
  job_t  job;
  logic  pop;

  mlsbs_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop)
  );

  mlsbs_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_in    (job),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule
